### sv/trls_pkg.sv
// Package for the threshold run-length segmenter.
// Holds the shared types, field widths, register map and queue depth.
// No dependencies; every other file imports it.
package trls_pkg;

    // Result field width, fixed by the output format
    localparam int RES_BITS = 24;

    // Pending run counter width and its ceiling
    localparam int PEND_BITS = 16;
    localparam logic [PEND_BITS-1:0] PEND_MAX = {PEND_BITS{1'b1}};

    // Configuration register width and APB geometry
    localparam int CFG_BITS = 16;
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 4;
    localparam int REG_IDX_BITS = 2;

    // Register indexes (byte address is 4 * index)
    localparam logic [REG_IDX_BITS-1:0] REG_ACT_LEVEL      = 2'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_QUIET_RUN_MIN  = 2'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_ACTIVE_RUN_MIN = 2'd2;

    // Register reset values
    localparam logic [CFG_BITS-1:0] ACT_LEVEL_RST      = 16'd0;
    localparam logic [CFG_BITS-1:0] QUIET_RUN_MIN_RST  = 16'd1;
    localparam logic [CFG_BITS-1:0] ACTIVE_RUN_MIN_RST = 16'd1;

    // Result queue: room for two results per item plus slack
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = FIFO_PTR_BITS + 1;

    typedef struct packed {
        logic [CFG_BITS-1:0] act_level;
        logic [CFG_BITS-1:0] quiet_run_min;
        logic [CFG_BITS-1:0] active_run_min;
    } cfg_t;

    typedef struct packed {
        logic                segment_is_active;
        logic [RES_BITS-1:0] segment_length;
        logic [RES_BITS-1:0] segment_index;
        logic                first_segment;
        logic                record_end;
    } seg_result_t;

endpackage

### sv/trls_if.sv
// Stream interfaces for the segmenter: sample input and segment output.
// Each carries valid, ready and payload; depends on trls_pkg.
interface trls_sample_if #(
    parameter int SAMPLE_BITS = 16
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          first_sample;
    logic                          last_sample;

    modport source (output valid, sample, first_sample, last_sample, input ready);
    modport sink (input valid, sample, first_sample, last_sample, output ready);
endinterface

interface trls_segment_if import trls_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                segment_is_active;
    logic [RES_BITS-1:0] segment_length;
    logic [RES_BITS-1:0] segment_index;
    logic                first_segment;
    logic                record_end;

    modport source (output valid, segment_is_active, segment_length, segment_index,
                    first_segment, record_end, input ready);
    modport sink (input valid, segment_is_active, segment_length, segment_index,
                  first_segment, record_end, output ready);
endinterface

### sv/trls_cfg_regs.sv
// APB configuration registers for the segmenter.
// Holds threshold and minimum run lengths; depends on trls_pkg.
module trls_cfg_regs import trls_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output cfg_t                     cfg
);

    cfg_t                    cfg_reg;
    logic                    wr_en;
    logic [REG_IDX_BITS-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[APB_ADDR_BITS-1:2];
    assign cfg     = cfg_reg;

    // Write the addressed register in the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.act_level      <= ACT_LEVEL_RST;
            cfg_reg.quiet_run_min  <= QUIET_RUN_MIN_RST;
            cfg_reg.active_run_min <= ACTIVE_RUN_MIN_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_ACT_LEVEL:      cfg_reg.act_level      <= pwdata[CFG_BITS-1:0];
                REG_QUIET_RUN_MIN:  cfg_reg.quiet_run_min  <= pwdata[CFG_BITS-1:0];
                REG_ACTIVE_RUN_MIN: cfg_reg.active_run_min <= pwdata[CFG_BITS-1:0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        unique case (reg_idx)
            REG_ACT_LEVEL:      prdata = APB_DATA_BITS'(cfg_reg.act_level);
            REG_QUIET_RUN_MIN:  prdata = APB_DATA_BITS'(cfg_reg.quiet_run_min);
            REG_ACTIVE_RUN_MIN: prdata = APB_DATA_BITS'(cfg_reg.active_run_min);
            default:            prdata = '0;
        endcase
    end

endmodule

### sv/trls_core.sv
// Segmenter datapath: input register, classification and run state update.
// Produces up to two results per sample; depends on trls_pkg.
module trls_core import trls_pkg::*; #(
    parameter int LENGTH_BITS = 24,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cfg_t                          cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] in_sample,
    input  logic                          in_first,
    input  logic                          in_last,
    input  logic                          fifo_room,
    output logic [1:0]                    push_n,
    output seg_result_t                   res_a,
    output seg_result_t                   res_b
);

    localparam int SUM_BITS = ((LENGTH_BITS > PEND_BITS) ? LENGTH_BITS : PEND_BITS) + 2;
    localparam int MAG_BITS = (SAMPLE_BITS > CFG_BITS) ? SAMPLE_BITS : CFG_BITS;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
    localparam logic [SUM_BITS-1:0] LEN_MAX_EXT = SUM_BITS'(LEN_MAX);

    // Input register stage
    logic                   item_valid_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic                   first_reg;
    logic                   last_reg;

    // Record state
    logic                   in_active_reg,  in_active_next;
    logic [LENGTH_BITS-1:0] run_length_reg, run_length_next;
    logic [PEND_BITS-1:0]   pending_reg,    pending_next;
    logic [LENGTH_BITS-1:0] quiet_cnt_reg,  quiet_cnt_next;
    logic [LENGTH_BITS-1:0] active_cnt_reg, active_cnt_next;
    logic                   any_closed_reg, any_closed_next;

    logic                   advance;
    logic [SAMPLE_BITS-1:0] mag;
    logic                   active;
    logic                   ia0, ia1, anyc0, anyc1;
    logic [LENGTH_BITS-1:0] rl0, rl1, qc0, qc1, ac0, ac1;
    logic [PEND_BITS-1:0]   pl0, pl_inc, limit;
    logic [SUM_BITS-1:0]    rl_sum, pl_ext;
    logic                   change, take_change;
    seg_result_t            closed_res, end_res;

    function automatic logic [LENGTH_BITS-1:0] sat_inc(input logic [LENGTH_BITS-1:0] c);
        sat_inc = (c == LEN_MAX) ? c : c + 1'b1;
    endfunction

    assign advance  = item_valid_reg & fifo_room;
    assign in_ready = ~item_valid_reg | fifo_room;

    // Load the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            sample_reg <= in_sample;
            first_reg  <= in_first;
            last_reg   <= in_last;
        end
    end

    // Classify: magnitude of the most negative sample wraps to the sign bit value
    assign mag    = sample_reg[SAMPLE_BITS-1] ? (~sample_reg + 1'b1) : sample_reg;
    assign active = MAG_BITS'(mag) >= MAG_BITS'(cfg.act_level);

    // Advance the run state for one sample
    always_comb
    begin
        // start of record
        ia0   = first_reg ? active : in_active_reg;
        rl0   = first_reg ? '0 : run_length_reg;
        pl0   = first_reg ? '0 : pending_reg;
        qc0   = first_reg ? '0 : quiet_cnt_reg;
        ac0   = first_reg ? '0 : active_cnt_reg;
        anyc0 = first_reg ? 1'b0 : any_closed_reg;

        change      = active != ia0;
        limit       = active ? cfg.active_run_min : cfg.quiet_run_min;
        pl_inc      = (pl0 != PEND_MAX) ? pl0 + 1'b1 : pl0;
        take_change = change && (pl_inc >= limit);

        closed_res.segment_is_active = ia0;
        closed_res.segment_length    = RES_BITS'(rl0);
        closed_res.segment_index     = RES_BITS'(ia0 ? ac0 : qc0);
        closed_res.first_segment     = ~anyc0;
        closed_res.record_end        = 1'b0;

        // fold the run back in, or open the new segment at the run length
        rl_sum = SUM_BITS'(rl0) + SUM_BITS'(pl0) + SUM_BITS'(1);
        pl_ext = SUM_BITS'(pl_inc);
        qc1    = (take_change && !ia0) ? sat_inc(qc0) : qc0;
        ac1    = (take_change && ia0) ? sat_inc(ac0) : ac0;
        anyc1  = anyc0 | take_change;
        ia1    = take_change ? active : ia0;
        if (take_change)
        begin
            rl1          = (pl_ext > LEN_MAX_EXT) ? LEN_MAX : LENGTH_BITS'(pl_ext);
            pending_next = '0;
        end
        else if (change)
        begin
            rl1          = rl0;
            pending_next = pl_inc;
        end
        else
        begin
            rl1          = (rl_sum > LEN_MAX_EXT) ? LEN_MAX : LENGTH_BITS'(rl_sum);
            pending_next = '0;
        end

        end_res.segment_is_active = ia1;
        end_res.segment_length    = RES_BITS'(rl1);
        end_res.segment_index     = RES_BITS'(ia1 ? ac1 : qc1);
        end_res.first_segment     = ~anyc1;
        end_res.record_end        = 1'b1;

        in_active_next  = ia1;
        run_length_next = rl1;
        quiet_cnt_next  = qc1;
        active_cnt_next = ac1;
        any_closed_next = anyc1;

        // end of record: drop pending samples, keep the segment class
        if (last_reg)
        begin
            run_length_next = '0;
            pending_next    = '0;
            quiet_cnt_next  = '0;
            active_cnt_next = '0;
            any_closed_next = 1'b0;
        end

        res_a  = take_change ? closed_res : end_res;
        res_b  = end_res;
        push_n = advance ? (2'(take_change) + 2'(last_reg)) : 2'd0;
    end

    // Commit state when the item moves into the result queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_active_reg  <= 1'b0;
            run_length_reg <= '0;
            pending_reg    <= '0;
            quiet_cnt_reg  <= '0;
            active_cnt_reg <= '0;
            any_closed_reg <= 1'b0;
        end
        else if (advance)
        begin
            in_active_reg  <= in_active_next;
            run_length_reg <= run_length_next;
            pending_reg    <= pending_next;
            quiet_cnt_reg  <= quiet_cnt_next;
            active_cnt_reg <= active_cnt_next;
            any_closed_reg <= any_closed_next;
        end
    end

    // Two results only when a change and the record end meet
    a_two_needs_last: assert property (@(posedge clk) disable iff (!rst_n)
        (push_n == 2'd2) |-> last_reg)
        else $error("two results without record end");

    // Record end leaves a cleared record behind
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && last_reg) |=> (!any_closed_reg && run_length_reg == '0))
        else $error("record state not cleared after record end");

    // A closed segment inside the record marks the record as started
    a_close_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && push_n != 2'd0 && !last_reg) |=> any_closed_reg)
        else $error("closed segment not recorded");

endmodule

### sv/trls_out_fifo.sv
// Result queue between the segmenter datapath and the output channel.
// Takes up to two results per cycle, delivers one; depends on trls_pkg.
module trls_out_fifo import trls_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [1:0]  push_n,
    input  seg_result_t push_a,
    input  seg_result_t push_b,
    output logic        room,
    output logic        out_valid,
    input  logic        out_ready,
    output seg_result_t out_data
);

    seg_result_t              entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_BITS-1:0] count_reg, count_next;
    logic [FIFO_PTR_BITS-1:0] wr_ptr_b;
    logic                     pop;

    assign room      = count_reg <= FIFO_CNT_BITS'(FIFO_DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign out_data  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid & out_ready;
    assign wr_ptr_b  = wr_ptr_reg + 1'b1;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_BITS'(push_n);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_BITS'(pop);
        count_next  = count_reg + FIFO_CNT_BITS'(push_n) - FIFO_CNT_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store incoming results in order
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push_a;
        end
        if (push_n == 2'd2)
        begin
            entry_reg[wr_ptr_b] <= push_b;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CNT_BITS'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push_n != 2'd0) |-> room)
        else $error("push without room for two results");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push_n == 2'd0 && !pop) |=> $stable(count_reg))
        else $error("occupancy changed without push or pop");

endmodule

### sv/threshold_run_length_segmenter.sv
// Threshold run-length segmenter, top level.
// A sample passes the input register and then the result queue before it is offered.
// Throughput: one sample per cycle while the result queue has room; a sample that closes
// a segment and ends the record gives two results, leaving one per cycle as the output takes them.
// Reset: asynchronous, clears the record state and queue; registers take
// threshold 0 and both minimum run lengths 1.
module threshold_run_length_segmenter import trls_pkg::*; #(
    parameter int LENGTH_BITS = 24,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    trls_sample_if.sink              samples,
    trls_segment_if.source           segments,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    cfg_t        cfg;
    logic        fifo_room;
    logic [1:0]  push_n;
    seg_result_t res_a;
    seg_result_t res_b;
    seg_result_t out_data;

    trls_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    trls_core #(
        .LENGTH_BITS (LENGTH_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .in_sample (samples.sample),
        .in_first  (samples.first_sample),
        .in_last   (samples.last_sample),
        .fifo_room (fifo_room),
        .push_n    (push_n),
        .res_a     (res_a),
        .res_b     (res_b)
    );

    trls_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_n    (push_n),
        .push_a    (res_a),
        .push_b    (res_b),
        .room      (fifo_room),
        .out_valid (segments.valid),
        .out_ready (segments.ready),
        .out_data  (out_data)
    );

    // Drive the output transaction payload
    assign segments.segment_is_active = out_data.segment_is_active;
    assign segments.segment_length    = out_data.segment_length;
    assign segments.segment_index     = out_data.segment_index;
    assign segments.first_segment     = out_data.first_segment;
    assign segments.record_end        = out_data.record_end;

endmodule

### test/tb_threshold_run_length_segmenter.sv
// Testbench for threshold_run_length_segmenter: random and directed sample records,
// an internal segment predictor and a field-by-field check of every output transaction.
// Depends on trls_pkg, trls_if.sv and the segmenter RTL.
module tb_threshold_run_length_segmenter;
    import trls_pkg::*;

    localparam int SMP_BITS = 16;
    localparam longint LEN_MAX = (64'd1 << RES_BITS) - 1;
    localparam int TIMEOUT_CYCLES = 500000;
    localparam int RANDOM_SAMPLES = 1550;
    localparam int RANDOM_PHASES = 12;

    typedef enum int {PACE_FULL, PACE_LIGHT, PACE_HEAVY} pace_e;

    typedef struct {
        logic signed [SMP_BITS-1:0] sample;
        logic                       first_sample;
        logic                       last_sample;
    } sample_item_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic pready;

    trls_sample_if #(.SAMPLE_BITS(SMP_BITS)) smp_if ();
    trls_segment_if seg_if ();

    threshold_run_length_segmenter #(
        .LENGTH_BITS(RES_BITS),
        .SAMPLE_BITS(SMP_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .samples(smp_if),
        .segments(seg_if),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #4 clk = ~clk;

    // Register shadow and segment tracking state
    cfg_t                cfg;
    logic                seg_active;
    logic [RES_BITS-1:0] open_len;
    logic [PEND_BITS-1:0] opp_run;
    logic [RES_BITS-1:0] quiet_segs;
    logic [RES_BITS-1:0] active_segs;
    logic                closed_any;

    sample_item_t pending_samples[$];
    seg_result_t  expected_segs[$];
    sample_item_t next_item;
    seg_result_t  want;

    pace_e src_pace = PACE_FULL;
    pace_e snk_pace = PACE_FULL;
    int src_gap;
    int snk_hold;
    int pushed_cnt = 0;
    int samples_taken = 0;
    int records_closed = 0;
    int segments_seen = 0;
    int settings_cnt = 0;
    int fail_cnt = 0;
    int cycle_cnt = 0;

    function automatic longint sat_len(longint v);
        return (v > LEN_MAX) ? LEN_MAX : v;
    endfunction

    function automatic void clear_record();
        open_len = '0;
        opp_run = '0;
        quiet_segs = '0;
        active_segs = '0;
        closed_any = 1'b0;
    endfunction

    // Emit the open segment and bump the count of its kind
    function automatic void close_segment(logic at_end);
        seg_result_t r;
        r.segment_is_active = seg_active;
        r.segment_length = open_len;
        r.segment_index = seg_active ? active_segs : quiet_segs;
        r.first_segment = !closed_any;
        r.record_end = at_end;
        expected_segs.push_back(r);
        if (seg_active)
            active_segs = RES_BITS'(sat_len(longint'(active_segs) + 1));
        else
            quiet_segs = RES_BITS'(sat_len(longint'(quiet_segs) + 1));
        closed_any = 1'b1;
    endfunction

    // Classify one accepted sample and queue the segments it closes
    function automatic void predict_segments(logic signed [SMP_BITS-1:0] s, logic first_s,
                                             logic last_s);
        int sv;
        int mag;
        logic act;
        logic [CFG_BITS-1:0] need;
        sv = s;
        mag = (sv < 0) ? -sv : sv;
        act = (mag >= int'(cfg.act_level));
        if (first_s)
        begin
            seg_active = act;
            clear_record();
        end
        if (act != seg_active)
        begin
            need = act ? cfg.active_run_min : cfg.quiet_run_min;
            if (opp_run != PEND_MAX)
                opp_run = opp_run + 1'b1;
            if (opp_run >= need)
            begin
                close_segment(1'b0);
                seg_active = act;
                open_len = RES_BITS'(sat_len(longint'(opp_run)));
                opp_run = '0;
            end
        end
        else
        begin
            open_len = RES_BITS'(sat_len(longint'(open_len) + longint'(opp_run) + 1));
            opp_run = '0;
        end
        if (last_s)
        begin
            close_segment(1'b1);
            clear_record();
        end
    endfunction

    function automatic int draw_wait(pace_e pace);
        case (pace)
            PACE_FULL: return 0;
            PACE_LIGHT: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
            default: return $urandom_range(0, 16);
        endcase
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            fail_cnt++;
        end
    endfunction

    function automatic void push_sample(logic signed [SMP_BITS-1:0] s, logic f, logic l);
        sample_item_t it;
        it.sample = s;
        it.first_sample = f;
        it.last_sample = l;
        pending_samples.push_back(it);
        pushed_cnt++;
    endfunction

    // Pick a sample of the wanted class, leaning on the threshold boundary
    function automatic logic signed [SMP_BITS-1:0] pick_sample(logic want_active);
        int lo;
        int hi;
        int mag;
        if (want_active)
        begin
            lo = int'(cfg.act_level);
            hi = 32768;
        end
        else
        begin
            lo = 0;
            hi = int'(cfg.act_level) - 1;
        end
        if (hi > 32768)
            hi = 32768;
        if (lo > hi)
        begin
            lo = 0;
            hi = 32768;
        end
        case ($urandom_range(0, 3))
            0: mag = lo;
            1: mag = hi;
            default: mag = $urandom_range(hi, lo);
        endcase
        if (mag == 32768)
            return 16'sh8000;
        return $urandom_range(0, 1) ? SMP_BITS'(-mag) : SMP_BITS'(mag);
    endfunction

    // Build a record of alternating runs sized around the current minimums
    function automatic void push_record(int n_items, logic with_first, logic with_last);
        logic cls;
        int run_left;
        int need;
        cls = 1'($urandom_range(0, 1));
        run_left = 0;
        for (int k = 0; k < n_items; k++)
        begin
            if (run_left == 0)
            begin
                cls = !cls;
                need = cls ? int'(cfg.active_run_min) : int'(cfg.quiet_run_min);
                if (need == 0)
                    need = 1;
                if (need > 10)
                    run_left = $urandom_range(1, 12);
                else
                    run_left = $urandom_range(1, 2 * need + 1);
            end
            push_sample(pick_sample(cls), with_first && k == 0, with_last && k == n_items - 1);
            run_left--;
        end
    endfunction

    function automatic logic [CFG_BITS-1:0] pick_minimum();
        case ($urandom_range(0, 5))
            0: return CFG_BITS'($urandom_range(0, 65535));
            1: return 16'd1;
            default: return CFG_BITS'($urandom_range(2, 8));
        endcase
    endfunction

    // Write one register over APB, then read it back
    task automatic write_reg(logic [REG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
        logic [APB_DATA_BITS-1:0] readback;
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= APB_DATA_BITS'(val);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_ACT_LEVEL: cfg.act_level = val;
            REG_QUIET_RUN_MIN: cfg.quiet_run_min = val;
            REG_ACTIVE_RUN_MIN: cfg.active_run_min = val;
            default: ;
        endcase
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(negedge clk);
            readback = prdata;
            @(posedge clk);
        end
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        check_field("register readback", APB_DATA_BITS'(val), readback);
    endtask

    task automatic write_config(logic [CFG_BITS-1:0] thr, logic [CFG_BITS-1:0] ivl,
                                logic [CFG_BITS-1:0] dur);
        write_reg(REG_ACT_LEVEL, thr);
        write_reg(REG_QUIET_RUN_MIN, ivl);
        write_reg(REG_ACTIVE_RUN_MIN, dur);
        settings_cnt++;
    endtask

    // Wait until every sample is taken and every segment has come out
    task automatic settle(int tail);
        while (samples_taken != pushed_cnt || expected_segs.size() != 0)
            @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    // Sample driver: predict on each accepted transaction, then offer the next
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            smp_if.valid <= 1'b0;
            src_gap = 0;
        end
        else
        begin
            if (smp_if.valid && smp_if.ready)
            begin
                predict_segments(smp_if.sample, smp_if.first_sample, smp_if.last_sample);
                samples_taken++;
                if (smp_if.last_sample)
                    records_closed++;
            end
            if (!smp_if.valid || smp_if.ready)
            begin
                if (src_gap > 0)
                begin
                    smp_if.valid <= 1'b0;
                    src_gap--;
                end
                else if (pending_samples.size() > 0)
                begin
                    next_item = pending_samples.pop_front();
                    smp_if.sample <= next_item.sample;
                    smp_if.first_sample <= next_item.first_sample;
                    smp_if.last_sample <= next_item.last_sample;
                    smp_if.valid <= 1'b1;
                    src_gap = draw_wait(src_pace);
                end
                else
                begin
                    smp_if.valid <= 1'b0;
                end
            end
        end
    end

    // Segment monitor: compare each accepted transaction, then stall at random
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            seg_if.ready <= 1'b0;
            snk_hold = 0;
        end
        else
        begin
            if (seg_if.valid && seg_if.ready)
            begin
                segments_seen++;
                if (expected_segs.size() == 0)
                begin
                    $error("segment with no expectation waiting: active %0d length %0d",
                           seg_if.segment_is_active, seg_if.segment_length);
                    fail_cnt++;
                end
                else
                begin
                    want = expected_segs.pop_front();
                    check_field("segment_is_active", 32'(want.segment_is_active),
                                32'(seg_if.segment_is_active));
                    check_field("segment_length", 32'(want.segment_length),
                                32'(seg_if.segment_length));
                    check_field("segment_index", 32'(want.segment_index),
                                32'(seg_if.segment_index));
                    check_field("first_segment", 32'(want.first_segment),
                                32'(seg_if.first_segment));
                    check_field("record_end", 32'(want.record_end), 32'(seg_if.record_end));
                end
                snk_hold = draw_wait(snk_pace);
            end
            if (snk_hold > 0)
            begin
                seg_if.ready <= 1'b0;
                snk_hold--;
            end
            else
            begin
                seg_if.ready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
        cycle_cnt <= cycle_cnt + 1;

    initial
    begin
        wait (cycle_cnt >= TIMEOUT_CYCLES);
        $display("threshold_run_length_segmenter verification failed");
        $finish;
    end

    initial
    begin
        int kind;
        int len;
        int goal;
        logic [CFG_BITS-1:0] thr;
        logic [CFG_BITS-1:0] ivl;
        logic [CFG_BITS-1:0] dur;

        // Known values on every input before reset releases
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        smp_if.valid = 1'b0;
        smp_if.sample = '0;
        smp_if.first_sample = 1'b0;
        smp_if.last_sample = 1'b0;
        seg_if.ready = 1'b0;
        cfg.act_level = ACT_LEVEL_RST;
        cfg.quiet_run_min = QUIET_RUN_MIN_RST;
        cfg.active_run_min = ACTIVE_RUN_MIN_RST;
        seg_active = 1'b0;
        clear_record();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: threshold boundary, folding, change on the last sample
        write_config(16'd100, 16'd3, 16'd2);
        // no start marker after reset: record opens quiet
        push_sample(16'sd5, 1'b0, 1'b0);
        push_sample(16'sd200, 1'b0, 1'b0);
        push_sample(-16'sd300, 1'b0, 1'b1);
        // no start marker after an end: class is kept, tentative quiet dropped
        push_sample(-16'sd100, 1'b0, 1'b0);
        push_sample(16'sd99, 1'b0, 1'b1);
        // change accepted on the last sample gives two segments
        push_sample(-16'sd99, 1'b1, 1'b0);
        push_sample(16'sd0, 1'b0, 1'b0);
        push_sample(16'sd32767, 1'b0, 1'b0);
        push_sample(16'sh8000, 1'b0, 1'b1);
        // pending quiet run at the end is dropped
        push_sample(16'sd1000, 1'b1, 1'b0);
        push_sample(-16'sd1000, 1'b0, 1'b0);
        push_sample(-16'sd1, 1'b0, 1'b0);
        push_sample(16'sd1, 1'b0, 1'b1);
        // short active run folds into the quiet segment
        push_sample(16'sd50, 1'b1, 1'b0);
        push_sample(16'sd150, 1'b0, 1'b0);
        push_sample(-16'sd50, 1'b0, 1'b0);
        push_sample(16'sd20, 1'b0, 1'b0);
        push_sample(16'sd30, 1'b0, 1'b0);
        push_sample(16'sd400, 1'b0, 1'b0);
        push_sample(16'sd500, 1'b0, 1'b0);
        push_sample(16'sd7, 1'b0, 1'b1);
        // one-sample record
        push_sample(16'sh8000, 1'b1, 1'b1);
        settle(4);

        // Directed: zero minimums act as one, top threshold
        write_config(16'd32768, 16'd0, 16'd0);
        push_sample(16'sh8000, 1'b1, 1'b0);
        push_sample(16'sd32767, 1'b0, 1'b0);
        push_sample(16'sh8000, 1'b0, 1'b1);
        settle(4);

        // Random phases, each with its own register setting
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    thr = 16'd0;
                    ivl = 16'd1;
                    dur = 16'd1;
                end
                1:
                begin
                    thr = 16'd32768;
                    ivl = 16'd65535;
                    dur = 16'd65535;
                end
                2:
                begin
                    thr = CFG_BITS'($urandom_range(1, 3000));
                    ivl = 16'd0;
                    dur = 16'd0;
                end
                3:
                begin
                    thr = 16'd65535;
                    ivl = pick_minimum();
                    dur = pick_minimum();
                end
                default:
                begin
                    thr = ($urandom_range(0, 3) == 0) ? CFG_BITS'($urandom_range(0, 65535))
                                                      : CFG_BITS'($urandom_range(1, 4000));
                    ivl = pick_minimum();
                    dur = pick_minimum();
                end
            endcase
            write_config(thr, ivl, dur);

            // Three stretches per phase, each with its own pacing
            for (int chunk = 0; chunk < 3; chunk++)
            begin
                src_pace = pace_e'($urandom_range(0, 2));
                snk_pace = pace_e'($urandom_range(0, 2));
                goal = pushed_cnt + RANDOM_SAMPLES / (RANDOM_PHASES * 3);
                while (pushed_cnt < goal)
                begin
                    kind = $urandom_range(0, 9);
                    case ($urandom_range(0, 9))
                        0: len = 1;
                        1: len = $urandom_range(60, 200);
                        default: len = $urandom_range(2, 40);
                    endcase
                    // keep the stretch at its share of the sample budget
                    if (len > goal - pushed_cnt)
                        len = goal - pushed_cnt;
                    if (kind < 7)
                        push_record(len, 1'b1, 1'b1);
                    else if (kind == 7)
                        push_record(len, 1'b1, 1'b0);
                    else if (kind == 8)
                        push_record(len, 1'b0, 1'b1);
                    else
                        repeat (len) push_sample(SMP_BITS'($urandom),
                                                 $urandom_range(0, 7) == 0,
                                                 $urandom_range(0, 7) == 0);
                end
                while (pending_samples.size() > 0)
                    @(posedge clk);
            end
            settle(4);
        end

        settle(8);
        $display("Ran %0d samples (%0d records closed) through %0d register settings",
                 samples_taken, records_closed, settings_cnt);
        $display("Checked %0d segments field by field", segments_seen);
        if (fail_cnt == 0)
            $display("threshold_run_length_segmenter verification clean");
        else
            $display("threshold_run_length_segmenter verification failed");
        $finish;
    end

endmodule

### sim.f
sv/trls_pkg.sv
sv/trls_if.sv
sv/trls_cfg_regs.sv
sv/trls_core.sv
sv/trls_out_fifo.sv
sv/threshold_run_length_segmenter.sv
test/tb_threshold_run_length_segmenter.sv
